@@ sv/ax25ae_pkg.sv @@
// Shared types and constants for the AX.25 address field encoder.
// No dependencies.
package ax25ae_pkg;

  localparam int CALL_CHARS = 6;
  localparam int IDX_W      = 3;  // byte index within one encoded address, 0..6

  typedef enum logic [1:0] {
    KIND_ADDR_CHAR  = 2'd0,
    KIND_ADDR_CLOSE = 2'd1,
    KIND_PATH_CHAR  = 2'd2,
    KIND_PATH_END   = 2'd3
  } kind_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'd32;
  localparam logic [3:0] SSID_HI  = 4'h3;   // upper nibble of the SSID byte
  localparam logic [3:0] SSID_MSK = 4'hF;

  typedef logic [CALL_CHARS-1:0][7:0] call_t;

  // One finished address, handed from the parser to the serializer.
  typedef struct packed {
    call_t      call;
    logic [3:0] sid;
  } rec_t;

endpackage

@@ sv/ax25ae_front.sv @@
// Parser: takes one character request per cycle, keeps the callsign and path
// token state and pushes each finished address. Depends on ax25ae_pkg.
module ax25ae_front
  import ax25ae_pkg::*;
#(
  parameter int MAX_HOPS     = 4,
  parameter int TOKEN_BUFFER = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  kind_t      kind,
  input  logic [7:0] ch,
  input  logic [3:0] ssid,
  output logic       push,
  output rec_t       push_rec
);

  localparam int TC_W  = $clog2(TOKEN_BUFFER);
  localparam int HOP_W = $clog2(MAX_HOPS + 1);
  localparam logic [TC_W-1:0]  TC_LAST = TC_W'(TOKEN_BUFFER - 1);
  localparam logic [HOP_W-1:0] HOP_MAX = HOP_W'(MAX_HOPS);
  localparam logic [2:0]       CLEN_FULL = 3'(CALL_CHARS);

  call_t            call_r, call_nxt;
  logic [2:0]       clen_r, clen_nxt;
  logic [TC_W-1:0]  tch_r, tch_nxt;
  logic             dash_r, dash_nxt;
  logic             digs_r, digs_nxt;
  logic [3:0]       acc_r, acc_nxt;
  logic [HOP_W-1:0] hop_r, hop_nxt;
  logic             open_r, open_nxt;

  logic do_store, do_close, do_end, go;
  logic [7:0] up_ch;

  assign up_ch = (ch >= CH_LC_A && ch <= CH_LC_Z) ? ch - CASE_OFS : ch;

  always_comb begin
    call_nxt = call_r;
    clen_nxt = clen_r;
    tch_nxt  = tch_r;
    dash_nxt = dash_r;
    digs_nxt = digs_r;
    acc_nxt  = acc_r;
    hop_nxt  = hop_r;
    open_nxt = open_r;
    do_store = 1'b0;
    do_close = 1'b0;
    do_end   = 1'b0;
    go       = 1'b0;
    push     = 1'b0;
    push_rec = '0;
    if (acc) begin
      case (kind)
        KIND_ADDR_CHAR: begin
          tch_nxt = '0; dash_nxt = 1'b0; digs_nxt = 1'b0; acc_nxt = '0; open_nxt = 1'b0;
          if (ch == CH_NUL) clen_nxt = CLEN_FULL;
          else do_store = 1'b1;
        end
        KIND_ADDR_CLOSE: begin
          tch_nxt = '0; dash_nxt = 1'b0; digs_nxt = 1'b0; acc_nxt = '0; open_nxt = 1'b0;
          push = 1'b1;
          push_rec.call = call_r;
          push_rec.sid  = ssid & SSID_MSK;
          call_nxt = {CALL_CHARS{CH_SPACE}};
          clen_nxt = '0;
        end
        KIND_PATH_CHAR: begin
          if (ch == CH_NUL) begin
            do_end = 1'b1;
          end else if (hop_r < HOP_MAX) begin
            if (!open_r) begin
              if (ch != CH_SPACE && ch != CH_COMMA) begin
                // new token: drop any uncommitted callsign
                call_nxt = {CALL_CHARS{CH_SPACE}};
                clen_nxt = '0;
                tch_nxt = '0; dash_nxt = 1'b0; digs_nxt = 1'b0; acc_nxt = '0;
                open_nxt = 1'b1;
                go = 1'b1;
              end
            end else if (ch == CH_COMMA) begin
              do_close = 1'b1;
            end else begin
              go = 1'b1;
            end
          end
          if (go) begin
            tch_nxt = tch_nxt + 1'b1;
            if (!dash_nxt) begin
              if (ch == CH_DASH) begin
                dash_nxt = 1'b1;
                digs_nxt = 1'b1;
              end else begin
                do_store = 1'b1;
              end
            end else if (digs_nxt) begin
              if (ch >= CH_ZERO && ch <= CH_NINE)
                acc_nxt = {acc_nxt[0], 3'b000} + {acc_nxt[2:0], 1'b0} + ch[3:0];
              else
                digs_nxt = 1'b0;
            end
            if (tch_nxt >= TC_LAST) do_close = 1'b1;
          end
        end
        KIND_PATH_END: do_end = 1'b1;
        default: ;
      endcase

      if (do_store && clen_nxt < CLEN_FULL) begin
        for (int i = 0; i < CALL_CHARS; i++) begin
          if (clen_nxt == 3'(i)) call_nxt[i] = up_ch;
        end
        clen_nxt = clen_nxt + 1'b1;
      end

      if (do_close || do_end) begin
        if (open_nxt && hop_nxt < HOP_MAX) begin
          push = 1'b1;
          push_rec.call = call_nxt;
          push_rec.sid  = acc_nxt;
          call_nxt = {CALL_CHARS{CH_SPACE}};
          clen_nxt = '0;
          hop_nxt  = hop_nxt + 1'b1;
        end
        tch_nxt = '0; dash_nxt = 1'b0; digs_nxt = 1'b0; acc_nxt = '0; open_nxt = 1'b0;
        if (do_end) hop_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      call_r <= {CALL_CHARS{CH_SPACE}};
      clen_r <= '0;
      tch_r  <= '0;
      dash_r <= 1'b0;
      digs_r <= 1'b0;
      acc_r  <= '0;
      hop_r  <= '0;
      open_r <= 1'b0;
    end else begin
      call_r <= call_nxt;
      clen_r <= clen_nxt;
      tch_r  <= tch_nxt;
      dash_r <= dash_nxt;
      digs_r <= digs_nxt;
      acc_r  <= acc_nxt;
      hop_r  <= hop_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

@@ sv/ax25ae_fifo.sv @@
// Two-entry queue of finished addresses between parser and serializer.
// Depends on ax25ae_pkg.
module ax25ae_fifo
  import ax25ae_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output rec_t head
);

  rec_t       mem [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
    else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count out of range");

endmodule

@@ sv/ax25ae_back.sv @@
// Serializer: pops a finished address and sends its seven bytes, one per
// cycle while out_tready is high, SSID byte last. Depends on ax25ae_pkg.
module ax25ae_back
  import ax25ae_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rec_valid,
  input  rec_t       rec,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  localparam logic [IDX_W-1:0] IDX_SID = IDX_W'(CALL_CHARS);

  rec_t             cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             busy_r;
  logic             done;

  assign out_tvalid = busy_r;
  assign out_tlast  = (idx_r == IDX_SID);
  assign done       = busy_r && out_tready && out_tlast;
  assign pop        = rec_valid && (!busy_r || done);

  always_comb begin
    out_tdata = {SSID_HI, cur_r.sid};
    for (int i = 0; i < CALL_CHARS; i++) begin
      if (idx_r == IDX_W'(i)) out_tdata = cur_r.call[i];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (busy_r && out_tready) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= IDX_SID)
    else $error("byte index past SSID byte");
  a_sid_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[7:4] == SSID_HI))
    else $error("SSID byte lacks 0x30 marker");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !rec_valid) |=> !out_tvalid)
    else $error("serializer stays busy with nothing queued");

endmodule

@@ sv/ax25_address_field_encoder_unit.sv @@
// Top level of the AX.25 address field encoder: parser, address queue and
// byte serializer. Depends on ax25ae_pkg, ax25ae_front, ax25ae_fifo, ax25ae_back.
//
//   channel | dir | tdata                      | tuser     | tlast
//   in_     | in  | [7:0] ch, [11:8] ssid      | [1:0] kind| -
//   out_    | out | [7:0] addr_byte            | -         | last_of_address
//
// The parser takes one request per cycle while the two-entry address queue
// has a free slot; any request waits while the queue is full.
// The serializer sends one byte per cycle while out_tready is high, seven bytes
// per address, so a burst of closing requests is held to its pace and the requests behind it wait.
// A closing request's address is written into the queue, then popped into the serializer's address register.
// Reset (rst_n low, synchronous) clears callsign to spaces, token state, hop count, queue and serializer.
// in_tready drops only while the queue is full; out_tready stalls hold the byte.
module ax25_address_field_encoder_unit
  import ax25ae_pkg::*;
#(
  parameter int MAX_HOPS     = 4,
  parameter int TOKEN_BUFFER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] ch, [11:8] ssid, [15:12] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] addr_byte
  output logic        out_tlast
);

  logic acc, push, pop, full, not_empty;
  rec_t push_rec, head;

  assign in_tready = !full;
  assign acc       = in_tvalid && in_tready;

  ax25ae_front #(
    .MAX_HOPS    (MAX_HOPS),
    .TOKEN_BUFFER(TOKEN_BUFFER)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .kind    (kind_t'(in_tuser)),
    .ch      (in_tdata[7:0]),
    .ssid    (in_tdata[11:8]),
    .push    (push),
    .push_rec(push_rec)
  );

  ax25ae_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (full),
    .not_empty(not_empty),
    .head     (head)
  );

  ax25ae_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (not_empty),
    .rec       (head),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

@@ test/ax25ae_addr_checker.sv @@
// Scoreboard for the AX.25 address field encoder: tracks parser state from the
// input requests, queues the address bytes they should produce and compares.
// Depends on ax25ae_pkg.
module ax25ae_addr_checker
  import ax25ae_pkg::*;
#(
  parameter int MAX_HOPS     = 4,
  parameter int TOKEN_BUFFER = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] ch, [11:8] ssid, [15:12] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] addr_byte
  input  logic        out_tlast,
  output int          errors,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
  } addr_octet_t;

  addr_octet_t exp_octets[$];
  addr_octet_t want;

  // parser shadow state
  logic [7:0] call_chars [CALL_CHARS];
  int         call_cnt;
  int         tok_len;
  int         hops;
  logic       dash_seen;
  logic       in_digits;
  logic       tok_open;
  logic [3:0] sid_acc;

  function automatic void clear_call();
    for (int i = 0; i < CALL_CHARS; i++) call_chars[i] = CH_SPACE;
    call_cnt = 0;
  endfunction

  function automatic void clear_tok();
    tok_len   = 0;
    dash_seen = 1'b0;
    in_digits = 1'b0;
    sid_acc   = 4'h0;
    tok_open  = 1'b0;
  endfunction

  function automatic void keep_char(logic [7:0] c);
    if (call_cnt < CALL_CHARS) begin
      call_chars[call_cnt] = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_OFS : c;
      call_cnt++;
    end
  endfunction

  function automatic void queue_address(logic [3:0] sid);
    for (int i = 0; i < CALL_CHARS; i++)
      exp_octets.push_back(addr_octet_t'{call_chars[i], 1'b0});
    exp_octets.push_back(addr_octet_t'{{SSID_HI, sid & SSID_MSK}, 1'b1});
    clear_call();
  endfunction

  function automatic void finish_token();
    if (tok_open && hops < MAX_HOPS) begin
      queue_address(sid_acc);
      hops++;
    end
    clear_tok();
  endfunction

  function automatic void finish_path();
    finish_token();
    hops = 0;
  endfunction

  function automatic void path_step(logic [7:0] c);
    int acc;
    if (c == CH_NUL) begin
      finish_path();
      return;
    end
    if (hops >= MAX_HOPS) return;
    if (!tok_open) begin
      if (c == CH_SPACE || c == CH_COMMA) return;
      clear_call();
      clear_tok();
      tok_open = 1'b1;
    end else if (c == CH_COMMA) begin
      finish_token();
      return;
    end
    tok_len++;
    if (!dash_seen) begin
      if (c == CH_DASH) begin
        dash_seen = 1'b1;
        in_digits = 1'b1;
      end else begin
        keep_char(c);
      end
    end else if (in_digits) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc     = int'(sid_acc) * 10 + int'(c) - int'(CH_ZERO);
        sid_acc = acc[3:0];
      end else begin
        in_digits = 1'b0;
      end
    end
    if (tok_len >= TOKEN_BUFFER - 1) finish_token();
  endfunction

  function automatic void predict(kind_t k, logic [7:0] c, logic [3:0] sid);
    case (k)
      KIND_ADDR_CHAR: begin
        clear_tok();
        if (c == CH_NUL) call_cnt = CALL_CHARS;  // string end freezes the callsign
        else keep_char(c);
      end
      KIND_ADDR_CLOSE: begin
        clear_tok();
        queue_address(sid);
      end
      KIND_PATH_CHAR: path_step(c);
      default:        finish_path();
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_call();
      clear_tok();
      hops = 0;
      errors = 0;
      checked = 0;
      exp_octets.delete();
    end else begin
      // outputs first: a byte leaving now cannot stem from a request taken now
      if (out_tvalid && out_tready) begin
        if (exp_octets.size() == 0) begin
          $display("%0t: byte expected none, got %h last %b", $time, out_tdata, out_tlast);
          errors = errors + 1;
        end else begin
          want = exp_octets.pop_front();
          checked = checked + 1;
          if (want.octet !== out_tdata || want.last !== out_tlast) begin
            $display("%0t: byte expected %h last %b, got %h last %b", $time,
                     want.octet, want.last, out_tdata, out_tlast);
            errors = errors + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict(kind_t'(in_tuser), in_tdata[7:0], in_tdata[11:8]);
    end
    pending <= exp_octets.size();
  end

endmodule

@@ test/testbench.sv @@
// Top of the encoder test: clock, reset, request stimulus and verdict.
// Depends on ax25ae_pkg, ax25_address_field_encoder_unit, ax25ae_addr_checker.
module testbench
  import ax25ae_pkg::*;
();

  localparam int HOPS       = 4;
  localparam int TOK_BUF    = 16;
  localparam int QUIET_MAX  = 4000;
  localparam int PHASE_REQS = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'h0;  // [7:0] ch, [11:8] ssid, [15:12] zero
  logic [1:0]  in_tuser = 2'd0;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] addr_byte
  logic        out_tlast;

  int errors, pending, checked;
  int sent = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ax25_address_field_encoder_unit #(
    .MAX_HOPS    (HOPS),
    .TOKEN_BUFFER(TOK_BUF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ax25ae_addr_checker #(
    .MAX_HOPS    (HOPS),
    .TOKEN_BUFFER(TOK_BUF)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("no handshake for %0d cycles, %0d bytes outstanding", quiet, pending);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // valid stays high after acceptance; the next call either lowers it or
  // loads the next request in that same step
  task automatic send(input kind_t k, input logic [7:0] c, input logic [3:0] sid);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'h0, sid, c};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] call_char();
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: return CH_LC_A + 8'($urandom_range(0, 25));
      8, 9, 10, 11, 12, 13:   return CH_LC_A - CASE_OFS + 8'($urandom_range(0, 25));
      14, 15, 16:             return CH_ZERO + 8'($urandom_range(0, 9));
      default:                return 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic gen_address();
    int n;
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) send(KIND_ADDR_CHAR, CH_NUL, 4'($urandom));
      else send(KIND_ADDR_CHAR, call_char(), 4'($urandom));
    end
    send(KIND_ADDR_CLOSE, 8'($urandom), 4'($urandom));
  endtask

  task automatic gen_path();
    int n_tok;
    repeat ($urandom_range(0, 2))
      send(KIND_PATH_CHAR, $urandom_range(0, 1) ? CH_SPACE : CH_COMMA, 4'($urandom));
    n_tok = $urandom_range(1, 6);  // beyond the hop limit now and then
    for (int h = 0; h < n_tok; h++) begin
      if ($urandom_range(0, 7) == 0) begin
        // long token, cut by the token buffer unless it stays below TOKEN_BUFFER - 1 chars
        repeat ($urandom_range(14, 17)) send(KIND_PATH_CHAR, call_char(), 4'($urandom));
      end else begin
        repeat ($urandom_range(1, 7)) send(KIND_PATH_CHAR, call_char(), 4'($urandom));
        if ($urandom_range(0, 3) != 0) begin
          send(KIND_PATH_CHAR, CH_DASH, 4'($urandom));
          repeat ($urandom_range(0, 3))
            send(KIND_PATH_CHAR, CH_ZERO + 8'($urandom_range(0, 9)), 4'($urandom));
          if ($urandom_range(0, 4) == 0) send(KIND_PATH_CHAR, call_char(), 4'($urandom));
        end
      end
      if (h < n_tok - 1 || $urandom_range(0, 3) == 0) begin
        send(KIND_PATH_CHAR, CH_COMMA, 4'($urandom));
        repeat ($urandom_range(0, 1)) send(KIND_PATH_CHAR, CH_SPACE, 4'($urandom));
      end
      // address char in mid path drops the open token
      if ($urandom_range(0, 11) == 0) send(KIND_ADDR_CHAR, call_char(), 4'($urandom));
    end
    if ($urandom_range(0, 3) == 0) send(KIND_PATH_CHAR, CH_NUL, 4'($urandom));
    else send(KIND_PATH_END, 8'($urandom), 4'($urandom));
  endtask

  initial begin
    int target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lowercase, high byte, string end freezing the callsign, max ssid
    send(KIND_ADDR_CHAR, "a", 4'h0);
    send(KIND_ADDR_CHAR, "z", 4'h0);
    send(KIND_ADDR_CHAR, 8'hFF, 4'h0);
    send(KIND_ADDR_CHAR, "M", 4'h0);
    send(KIND_ADDR_CHAR, CH_NUL, 4'h0);
    send(KIND_ADDR_CHAR, "Q", 4'h0);
    send(KIND_ADDR_CLOSE, 8'h00, 4'hF);
    // empty callsign, all spaces
    send(KIND_ADDR_CLOSE, 8'hFF, 4'h0);
    // leading separators, two-digit ssid wrapping modulo 16
    send(KIND_PATH_CHAR, CH_SPACE, 4'h0);
    send(KIND_PATH_CHAR, CH_COMMA, 4'h0);
    send(KIND_PATH_CHAR, "k", 4'h0);
    send(KIND_PATH_CHAR, "1", 4'h0);
    send(KIND_PATH_CHAR, CH_DASH, 4'h0);
    send(KIND_PATH_CHAR, "1", 4'h0);
    send(KIND_PATH_CHAR, "9", 4'h0);
    send(KIND_PATH_CHAR, CH_COMMA, 4'h0);
    // no digit right after the dash, then NUL as end of path
    send(KIND_PATH_CHAR, "b", 4'h0);
    send(KIND_PATH_CHAR, CH_DASH, 4'h0);
    send(KIND_PATH_CHAR, "x", 4'h0);
    send(KIND_PATH_CHAR, "5", 4'h0);
    send(KIND_PATH_CHAR, CH_NUL, 4'h0);
    // end of path with nothing open
    send(KIND_PATH_END, 8'hFF, 4'hF);
    // address char abandons the path token
    send(KIND_PATH_CHAR, "c", 4'h0);
    send(KIND_ADDR_CHAR, "d", 4'h0);
    send(KIND_ADDR_CLOSE, 8'h00, 4'h5);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 35 : (ph == 1) ? 78 : 0;
      rx_idle = (ph == 0) ? 78 : (ph == 1) ? 35 : 0;
      target  = sent + PHASE_REQS;
      while (sent < target) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7:            gen_address();
          8, 9, 10, 11, 12, 13, 14, 15, 16:  gen_path();
          default: repeat ($urandom_range(1, 3))
                     send(kind_t'($urandom_range(0, 3)), 8'($urandom), 4'($urandom));
        endcase
      end
      drain();  // sender holds off until every address byte is out
    end

    repeat (40) @(posedge clk);
    $display("%0d requests driven, %0d address bytes compared", sent, checked);
    $display("three stall mixes: slow receiver, slow sender, none");
    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches, %0d bytes outstanding", errors, pending);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ax25ae_pkg.sv
sv/ax25ae_front.sv
sv/ax25ae_fifo.sv
sv/ax25ae_back.sv
sv/ax25_address_field_encoder_unit.sv
test/ax25ae_addr_checker.sv
test/testbench.sv
